// ----- rtl/nmps_pkg.sv -----
// Shared types, codes and sizing constants for the nearest point match scorer.
`timescale 1ns / 1ps

package nmps_pkg;

    // Table and coordinate sizing
    localparam int MAX_POINTS   = 256;
    localparam int COORD_BITS   = 16;
    localparam int COORD_IN_W   = 16;
    localparam int IDX_W        = $clog2(MAX_POINTS);
    localparam int CNT_W        = $clog2(MAX_POINTS + 1);
    localparam int OUT_IDX_W    = 8;
    localparam int TOTAL_W      = 16;
    localparam int WORD_W       = 2 * COORD_BITS;

    // Distance arithmetic widths
    localparam int DIFF_W       = COORD_BITS + 1;
    localparam int PROD_W       = 2 * COORD_BITS;
    localparam int SUM_W        = PROD_W + 1;
    localparam int ROOT_W       = COORD_BITS + 1;
    localparam int RAD_W        = 2 * ROOT_W;
    localparam int REM_W        = ROOT_W + 4;
    localparam int ISQRT_STAGES = ROOT_W;

    // Tag delay: memory read, difference, square, sum, then the root stages
    localparam int PIPE_DEPTH   = ISQRT_STAGES + 4;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef enum logic [1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_QUERY = 2'd1,
        FUNC_CLEAR = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        ST_LOADED  = 3'd0,
        ST_QUERY   = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_FULL    = 3'd3,
        ST_CLEARED = 3'd4
    } status_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic clear;
        logic report_empty;
        logic query_start;
        logic scan_step;
        logic finish;
    } nmps_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic empty;
        logic scan_last;
        logic scan_done;
    } nmps_sts_t;

    // Entry tag that travels alongside the distance pipeline
    typedef struct packed {
        logic             valid;
        logic             last;
        logic [IDX_W-1:0] idx;
    } nmps_tag_t;

endpackage

// ----- rtl/nmps_isqrt.sv -----
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps

module nmps_isqrt
    import nmps_pkg::*;
(
    input  logic              clk,
    input  logic [RAD_W-1:0]  rad,
    output logic [ROOT_W-1:0] root
);

    logic [RAD_W-1:0]  rad_reg  [ISQRT_STAGES];
    logic [REM_W-1:0]  rem_reg  [ISQRT_STAGES];
    logic [ROOT_W-1:0] root_reg [ISQRT_STAGES];

    logic [RAD_W-1:0]  rad_next  [ISQRT_STAGES];
    logic [REM_W-1:0]  rem_next  [ISQRT_STAGES];
    logic [ROOT_W-1:0] root_next [ISQRT_STAGES];

    // Each stage brings down two radicand bits and tries one root bit
    always_comb
    begin
        logic [RAD_W-1:0]  p_rad;
        logic [REM_W-1:0]  p_rem;
        logic [ROOT_W-1:0] p_root;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        for (int s = 0; s < ISQRT_STAGES; s++)
        begin
            if (s == 0)
            begin
                p_rad  = rad;
                p_rem  = '0;
                p_root = '0;
            end
            else
            begin
                p_rad  = rad_reg[s-1];
                p_rem  = rem_reg[s-1];
                p_root = root_reg[s-1];
            end
            rem_sh = {p_rem[REM_W-3:0], p_rad[RAD_W-1 -: 2]};
            trial  = REM_W'({p_root, 2'b01});
            rad_next[s] = {p_rad[RAD_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next[s]  = rem_sh - trial;
                root_next[s] = {p_root[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[s]  = rem_sh;
                root_next[s] = {p_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    // Advance all stages every cycle
    always_ff @(posedge clk)
    begin
        for (int s = 0; s < ISQRT_STAGES; s++)
        begin
            rad_reg[s]  <= rad_next[s];
            rem_reg[s]  <= rem_next[s];
            root_reg[s] <= root_next[s];
        end
    end

    assign root = root_reg[ISQRT_STAGES-1];

endmodule

// ----- rtl/nmps_lane.sv -----
// One point table with its distance pipeline: read, difference, square, sum, root.
`timescale 1ns / 1ps

module nmps_lane
    import nmps_pkg::*;
(
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [IDX_W-1:0]             wr_addr,
    input  logic signed [COORD_BITS-1:0] wr_x,
    input  logic signed [COORD_BITS-1:0] wr_y,
    input  logic [IDX_W-1:0]             rd_addr,
    input  logic signed [COORD_BITS-1:0] q_x,
    input  logic signed [COORD_BITS-1:0] q_y,
    output logic [ROOT_W-1:0]            distance
);

    logic [WORD_W-1:0]        mem [MAX_POINTS];
    logic [WORD_W-1:0]        rd_reg;
    logic signed [DIFF_W-1:0] dx_reg;
    logic signed [DIFF_W-1:0] dy_reg;
    logic [PROD_W-1:0]        sqx_reg;
    logic [PROD_W-1:0]        sqy_reg;
    logic [SUM_W-1:0]         sum_reg;

    logic signed [COORD_BITS-1:0] rd_x;
    logic signed [COORD_BITS-1:0] rd_y;
    logic signed [DIFF_W-1:0]     dx_next;
    logic signed [DIFF_W-1:0]     dy_next;
    logic signed [2*DIFF_W-1:0]   px;
    logic signed [2*DIFF_W-1:0]   py;

    // Table write on load
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_x, wr_y};
        end
    end

    // Registered table read
    always_ff @(posedge clk)
    begin
        rd_reg <= mem[rd_addr];
    end

    assign rd_x = rd_reg[WORD_W-1 -: COORD_BITS];
    assign rd_y = rd_reg[COORD_BITS-1:0];

    // Coordinate differences, one bit wider than a coordinate
    assign dx_next = $signed({q_x[COORD_BITS-1], q_x}) - $signed({rd_x[COORD_BITS-1], rd_x});
    assign dy_next = $signed({q_y[COORD_BITS-1], q_y}) - $signed({rd_y[COORD_BITS-1], rd_y});

    // Squares fit in PROD_W bits since each difference magnitude stays below 2^COORD_BITS
    assign px = dx_reg * dx_reg;
    assign py = dy_reg * dy_reg;

    // Hold the distance pipeline stages
    always_ff @(posedge clk)
    begin
        dx_reg  <= dx_next;
        dy_reg  <= dy_next;
        sqx_reg <= px[PROD_W-1:0];
        sqy_reg <= py[PROD_W-1:0];
        sum_reg <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
    end

    nmps_isqrt u_isqrt (
        .clk  (clk),
        .rad  (RAD_W'(sum_reg)),
        .root (distance)
    );

endmodule

// ----- rtl/nmps_dp.sv -----
// Datapath: tables, scan counter, tag line, best-entry tracking, counts and result register.
`timescale 1ns / 1ps

module nmps_dp
    import nmps_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  nmps_cmd_t                    cmd,
    output nmps_sts_t                    sts,
    input  logic signed [COORD_IN_W-1:0] x_first,
    input  logic signed [COORD_IN_W-1:0] y_first,
    input  logic signed [COORD_IN_W-1:0] x_last,
    input  logic signed [COORD_IN_W-1:0] y_last,
    output logic                         done,
    output logic [2:0]                   status,
    output logic [OUT_IDX_W-1:0]         first_index,
    output logic [OUT_IDX_W-1:0]         last_index,
    output logic                         matched,
    output logic [TOTAL_W-1:0]           correct_count,
    output logic [TOTAL_W-1:0]           query_count,
    output logic [TOTAL_W-1:0]           denominator
);

    logic [CNT_W-1:0]   entry_reg;
    logic [TOTAL_W-1:0] correct_reg;
    logic [TOTAL_W-1:0] query_reg;
    logic [IDX_W-1:0]   scan_idx_reg;
    nmps_tag_t          tag_reg [PIPE_DEPTH];

    logic signed [COORD_BITS-1:0] qxf_reg;
    logic signed [COORD_BITS-1:0] qyf_reg;
    logic signed [COORD_BITS-1:0] qxl_reg;
    logic signed [COORD_BITS-1:0] qyl_reg;

    logic [ROOT_W-1:0] best_df_reg;
    logic [ROOT_W-1:0] best_dl_reg;
    logic [IDX_W-1:0]  best_if_reg;
    logic [IDX_W-1:0]  best_il_reg;

    logic                 done_reg;
    status_t              status_reg;
    logic [OUT_IDX_W-1:0] fi_reg;
    logic [OUT_IDX_W-1:0] li_reg;
    logic                 m_reg;
    logic [TOTAL_W-1:0]   cc_reg;
    logic [TOTAL_W-1:0]   qc_reg;
    logic [TOTAL_W-1:0]   den_reg;

    logic               full;
    logic               wr_en;
    logic [ROOT_W-1:0]  dist_f;
    logic [ROOT_W-1:0]  dist_l;
    nmps_tag_t          tag_out;
    logic               upd_f;
    logic               upd_l;
    logic [IDX_W-1:0]   fi_now;
    logic [IDX_W-1:0]   li_now;
    logic               match_now;

    logic [CNT_W-1:0]     entry_next;
    logic [TOTAL_W-1:0]   correct_next;
    logic [TOTAL_W-1:0]   query_next;
    logic                 res_valid;
    status_t              res_status;
    logic [OUT_IDX_W-1:0] res_fi;
    logic [OUT_IDX_W-1:0] res_li;
    logic                 res_m;
    logic [TOTAL_W-1:0]   res_den;

    assign full  = (entry_reg == CNT_W'(MAX_POINTS));
    assign wr_en = cmd.load && !full;

    // Status toward the controller
    assign sts.empty     = (entry_reg == '0);
    assign sts.scan_last = ((CNT_W'(scan_idx_reg) + CNT_W'(1)) == entry_reg);
    assign sts.scan_done = tag_out.valid && tag_out.last;

    // Table lanes
    nmps_lane u_lane_first (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (entry_reg[IDX_W-1:0]),
        .wr_x     (x_first[COORD_BITS-1:0]),
        .wr_y     (y_first[COORD_BITS-1:0]),
        .rd_addr  (scan_idx_reg),
        .q_x      (qxf_reg),
        .q_y      (qyf_reg),
        .distance (dist_f)
    );

    nmps_lane u_lane_last (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (entry_reg[IDX_W-1:0]),
        .wr_x     (x_last[COORD_BITS-1:0]),
        .wr_y     (y_last[COORD_BITS-1:0]),
        .rd_addr  (scan_idx_reg),
        .q_x      (qxl_reg),
        .q_y      (qyl_reg),
        .distance (dist_l)
    );

    // Latch the query point on query start
    always_ff @(posedge clk)
    begin
        if (cmd.query_start)
        begin
            qxf_reg <= x_first[COORD_BITS-1:0];
            qyf_reg <= y_first[COORD_BITS-1:0];
            qxl_reg <= x_last[COORD_BITS-1:0];
            qyl_reg <= y_last[COORD_BITS-1:0];
        end
    end

    // Rewind the scan address on query start, else advance it on each scan step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
        end
        else if (cmd.query_start)
        begin
            scan_idx_reg <= '0;
        end
        else if (cmd.scan_step)
        begin
            scan_idx_reg <= scan_idx_reg + IDX_W'(1);
        end
    end

    // Tag line that matches the lane latency
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < PIPE_DEPTH; s++)
            begin
                tag_reg[s] <= '0;
            end
        end
        else
        begin
            tag_reg[0] <= '{valid: cmd.scan_step, last: sts.scan_last, idx: scan_idx_reg};
            for (int s = 1; s < PIPE_DEPTH; s++)
            begin
                tag_reg[s] <= tag_reg[s-1];
            end
        end
    end

    assign tag_out = tag_reg[PIPE_DEPTH-1];

    // Keep the first entry with the strictly smallest distance
    assign upd_f  = tag_out.valid && ((tag_out.idx == '0) || (dist_f < best_df_reg));
    assign upd_l  = tag_out.valid && ((tag_out.idx == '0) || (dist_l < best_dl_reg));
    assign fi_now = upd_f ? tag_out.idx : best_if_reg;
    assign li_now = upd_l ? tag_out.idx : best_il_reg;
    assign match_now = (fi_now == li_now);

    always_ff @(posedge clk)
    begin
        if (upd_f)
        begin
            best_df_reg <= dist_f;
            best_if_reg <= tag_out.idx;
        end
        if (upd_l)
        begin
            best_dl_reg <= dist_l;
            best_il_reg <= tag_out.idx;
        end
    end

    // Next counts and the result for this cycle's command
    always_comb
    begin
        entry_next   = entry_reg;
        correct_next = correct_reg;
        query_next   = query_reg;
        res_valid    = 1'b0;
        res_status   = ST_LOADED;
        res_fi       = '0;
        res_li       = '0;
        res_m        = 1'b0;
        if (cmd.load)
        begin
            res_valid = 1'b1;
            if (full)
            begin
                res_status = ST_FULL;
            end
            else
            begin
                entry_next = entry_reg + CNT_W'(1);
                res_status = ST_LOADED;
            end
        end
        if (cmd.clear)
        begin
            res_valid    = 1'b1;
            res_status   = ST_CLEARED;
            entry_next   = '0;
            correct_next = '0;
            query_next   = '0;
        end
        if (cmd.report_empty)
        begin
            res_valid  = 1'b1;
            res_status = ST_EMPTY;
        end
        if (cmd.finish)
        begin
            res_valid  = 1'b1;
            res_status = ST_QUERY;
            res_fi     = OUT_IDX_W'(fi_now);
            res_li     = OUT_IDX_W'(li_now);
            res_m      = match_now;
            if (query_reg != TOTAL_MAX)
            begin
                query_next = query_reg + TOTAL_W'(1);
            end
            if (match_now && (correct_reg != TOTAL_MAX))
            begin
                correct_next = correct_reg + TOTAL_W'(1);
            end
        end
        if (TOTAL_W'(entry_next) > query_next)
        begin
            res_den = TOTAL_W'(entry_next);
        end
        else
        begin
            res_den = query_next;
        end
    end

    // Hold counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg   <= '0;
            correct_reg <= '0;
            query_reg   <= '0;
        end
        else
        begin
            entry_reg   <= entry_next;
            correct_reg <= correct_next;
            query_reg   <= query_next;
        end
    end

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= res_valid;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            status_reg <= res_status;
            fi_reg     <= res_fi;
            li_reg     <= res_li;
            m_reg      <= res_m;
            cc_reg     <= correct_next;
            qc_reg     <= query_next;
            den_reg    <= res_den;
        end
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign first_index   = fi_reg;
    assign last_index    = li_reg;
    assign matched       = m_reg;
    assign correct_count = cc_reg;
    assign query_count   = qc_reg;
    assign denominator   = den_reg;

endmodule

// ----- rtl/nmps_ctrl.sv -----
// Controller: decodes commands and sequences the table scan for queries.
`timescale 1ns / 1ps

module nmps_ctrl
    import nmps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] func,
    input  nmps_sts_t  sts,
    output nmps_cmd_t  cmd,
    output logic       busy
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_DRAIN = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign busy = (state_reg != S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (func_t'(func))
                        FUNC_LOAD:
                        begin
                            cmd.load = 1'b1;
                        end
                        FUNC_CLEAR:
                        begin
                            cmd.clear = 1'b1;
                        end
                        FUNC_QUERY:
                        begin
                            if (sts.empty)
                            begin
                                cmd.report_empty = 1'b1;
                            end
                            else
                            begin
                                cmd.query_start = 1'b1;
                                state_next      = S_SCAN;
                            end
                        end
                        default:
                        begin
                            // drop the unused code
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (sts.scan_done)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/nearest_point_match_scorer.sv -----
// Top level of the nearest point match scorer: controller plus datapath.
//
//   channel   transfer when     payload
//   -------   ---------------   -------------------------------------------------------
//   command   start & !busy     func, x_first, y_first, x_last, y_last
//   result    done (1 cycle)    status, first_index, last_index, matched,
//                               correct_count, query_count, denominator
//
// Load, clear and a query on an empty table give done one cycle after the transfer.
// A query over N stored entries scans both tables at one entry per cycle through a
// 21-stage distance pipeline (read, difference, square, sum, 17 root stages); done
// follows once the last entry has left the pipeline, and busy stays high until then.
// Reset clears the entry, correct and query counts; table contents are not cleared.
// Results cannot be held off: each is shown for exactly one cycle.
`timescale 1ns / 1ps

module nearest_point_match_scorer
    import nmps_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   func,
    input  logic signed [COORD_IN_W-1:0] x_first,
    input  logic signed [COORD_IN_W-1:0] y_first,
    input  logic signed [COORD_IN_W-1:0] x_last,
    input  logic signed [COORD_IN_W-1:0] y_last,
    output logic                         done,
    output logic [2:0]                   status,
    output logic [OUT_IDX_W-1:0]         first_index,
    output logic [OUT_IDX_W-1:0]         last_index,
    output logic                         matched,
    output logic [TOTAL_W-1:0]           correct_count,
    output logic [TOTAL_W-1:0]           query_count,
    output logic [TOTAL_W-1:0]           denominator
);

    nmps_cmd_t cmd;
    nmps_sts_t sts;

    nmps_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (func),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    nmps_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .x_first       (x_first),
        .y_first       (y_first),
        .x_last        (x_last),
        .y_last        (y_last),
        .done          (done),
        .status        (status),
        .first_index   (first_index),
        .last_index    (last_index),
        .matched       (matched),
        .correct_count (correct_count),
        .query_count   (query_count),
        .denominator   (denominator)
    );

endmodule
